// File: hdl/qrs_pkg.sv
// shared types and constants for the quadratic root solver
// no dependencies; every other file in hdl uses this package
package qrs_pkg;

   localparam int COEF_WIDTH  = 16;
   localparam int FRAC_BITS   = 16;
   localparam int ROOT_WIDTH  = 48;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      KIND_INFINITE = 3'd0,
      KIND_NONE     = 3'd1,
      KIND_LINEAR   = 3'd2,
      KIND_DOUBLE   = 3'd3,
      KIND_TWO      = 3'd4
   } kind_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] coef_quad;
      logic signed [COEF_WIDTH-1:0] coef_lin;
      logic signed [COEF_WIDTH-1:0] coef_const;
   } req_type;

   typedef struct packed {
      kind_type                     root_kind;
      logic signed [ROOT_WIDTH-1:0] root_first;
      logic signed [ROOT_WIDTH-1:0] root_second;
   } rsp_type;

   // what travels alongside the square root: kind, numerator base and denominator
   typedef struct packed {
      kind_type                   kind;
      logic signed [COEF_WIDTH:0] nbase;
      logic signed [COEF_WIDTH:0] den;
   } side_type;

   typedef struct packed {
      side_type                  side;
      logic [2*COEF_WIDTH:0]     disc;
   } entry_type;

endpackage

// File: hdl/qrs_front.sv
// front end: takes coefficient words, forms the discriminant and classifies
// depends on qrs_pkg
module qrs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qrs_pkg::req_type    req,
   output logic                out_valid,
   input  logic                out_ready,
   output qrs_pkg::entry_type  out_entry
);
   localparam int CW = qrs_pkg::COEF_WIDTH;
   localparam int DW = 2*CW + 3;

   logic                     f1_valid_ff;
   logic signed [CW-1:0]     a_ff, b_ff, c_ff;
   logic signed [2*CW-1:0]   bb_ff, ac_ff;
   logic signed [2*CW-1:0]   bb_in, ac_in;
   logic                     f2_valid_ff;
   qrs_pkg::entry_type       entry_ff, entry_in;
   logic signed [DW-1:0]     disc;
   logic                     load1, load2;

   assign load2     = !f2_valid_ff || out_ready;
   assign load1     = !f1_valid_ff || load2;
   assign req_ready = load1;
   assign out_valid = f2_valid_ff;
   assign out_entry = entry_ff;

   assign bb_in = req.coef_lin * req.coef_lin;
   assign ac_in = req.coef_quad * req.coef_const;
   assign disc  = DW'(bb_ff) - (DW'(ac_ff) <<< 2);

   always_comb begin
      entry_in.side.kind  = qrs_pkg::KIND_NONE;
      entry_in.side.nbase = '0;
      entry_in.side.den   = (CW+1)'(1);
      entry_in.disc       = '0;
      if (a_ff == '0) begin
         if (b_ff == '0) begin
            entry_in.side.kind = (c_ff == '0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NONE;
         end else begin
            entry_in.side.kind  = qrs_pkg::KIND_LINEAR;
            entry_in.side.nbase = -((CW+1)'(c_ff));
            entry_in.side.den   = (CW+1)'(b_ff);
         end
      end else if (disc == '0) begin
         entry_in.side.kind  = qrs_pkg::KIND_DOUBLE;
         entry_in.side.nbase = -((CW+1)'(b_ff));
         entry_in.side.den   = (CW+1)'(a_ff) <<< 1;
      end else if (!disc[DW-1]) begin
         entry_in.side.kind  = qrs_pkg::KIND_TWO;
         entry_in.side.nbase = -((CW+1)'(b_ff));
         entry_in.side.den   = (CW+1)'(a_ff) <<< 1;
         entry_in.disc       = disc[2*CW:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         if (load1) f1_valid_ff <= req_valid;
         if (load2) f2_valid_ff <= f1_valid_ff;
      end
      if (load1 && req_valid) begin
         a_ff  <= req.coef_quad;
         b_ff  <= req.coef_lin;
         c_ff  <= req.coef_const;
         bb_ff <= bb_in;
         ac_ff <= ac_in;
      end
      if (load2) entry_ff <= entry_in;
   end

endmodule

// File: hdl/qrs_queue.sv
// short queue between the front end and the arithmetic back end
// depends on qrs_pkg
module qrs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qrs_pkg::entry_type  push_entry,
   input  logic                pop,
   output qrs_pkg::entry_type  head_entry,
   output logic                empty,
   output logic                full
);
   localparam int QD  = qrs_pkg::QUEUE_DEPTH;
   localparam int QPW = $clog2(QD);
   localparam int QCW = $clog2(QD + 1);

   qrs_pkg::entry_type ents_ff [QD];
   logic [QPW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0]     count_ff;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == QCW'(QD));
   assign head_entry = ents_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == QPW'(QD-1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == QPW'(QD-1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
      if (push) ents_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// File: hdl/qrs_sqrt.sv
// pipelined square root of disc * 4^FRAC_BITS, one root bit per stage
// depends on qrs_pkg
module qrs_sqrt #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        en,
   input  logic                                        in_valid,
   input  qrs_pkg::entry_type                          in_entry,
   output logic                                        out_valid,
   output qrs_pkg::side_type                           out_side,
   output logic [qrs_pkg::COEF_WIDTH+FRAC_BITS:0]      out_root
);
   localparam int CW  = qrs_pkg::COEF_WIDTH;
   localparam int SW  = CW + 1 + FRAC_BITS;
   localparam int RW  = 2*SW;
   localparam int RMW = SW + 2;

   logic              v_ff    [SW];
   qrs_pkg::side_type side_ff [SW];
   logic [SW-1:0]     root_ff [SW];
   logic [RMW-1:0]    rem_ff  [SW-1];
   logic [RW-1:0]     rad_ff  [SW-1];
   logic [RW-1:0]     rad0;

   assign rad0 = RW'(in_entry.disc) << (2*FRAC_BITS);

   for (genvar s = 0; s < SW; s++) begin : g_stage
      logic              v_prev;
      qrs_pkg::side_type side_prev;
      logic [SW-1:0]     root_prev;
      logic [RMW-1:0]    rem_prev;
      logic [RW-1:0]     rad_prev;
      logic [RMW-1:0]    shifted, trial;
      logic              ge;

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign side_prev = in_entry.side;
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign rad_prev  = rad0;
      end else begin : g_next
         assign v_prev    = v_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
      end

      assign shifted = {rem_prev[RMW-3:0], rad_prev[RW-1 -: 2]};
      assign trial   = {root_prev, 2'b01};
      assign ge      = (shifted >= trial);

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (en) v_ff[s] <= v_prev;
         if (en) begin
            side_ff[s] <= side_prev;
            root_ff[s] <= {root_prev[SW-2:0], ge};
         end
      end

      if (s < SW-1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= ge ? (shifted - trial) : shifted;
               rad_ff[s] <= rad_prev << 2;
            end
         end
      end
   end

   assign out_valid = v_ff[SW-1];
   assign out_side  = side_ff[SW-1];
   assign out_root  = root_ff[SW-1];

endmodule

// File: hdl/qrs_div.sv
// two-lane pipelined divider sharing one denominator, one quotient bit per stage
// magnitudes are divided; the sign of each lane comes out beside its quotient
// depends on qrs_pkg
module qrs_div #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           en,
   input  logic                                           in_valid,
   input  qrs_pkg::kind_type                              in_kind,
   input  logic signed [qrs_pkg::COEF_WIDTH+FRAC_BITS+2:0] num_first,
   input  logic signed [qrs_pkg::COEF_WIDTH+FRAC_BITS+2:0] num_second,
   input  logic signed [qrs_pkg::COEF_WIDTH:0]            den,
   output logic                                           out_valid,
   output qrs_pkg::kind_type                              out_kind,
   output logic [qrs_pkg::COEF_WIDTH+FRAC_BITS+2:0]       quo_first,
   output logic [qrs_pkg::COEF_WIDTH+FRAC_BITS+2:0]       quo_second,
   output logic [1:0]                                     quo_neg
);
   localparam int CW  = qrs_pkg::COEF_WIDTH;
   localparam int NW  = CW + FRAC_BITS + 3;
   localparam int DMW = CW + 1;
   localparam int RMW = CW + 2;

   logic              v_ff    [NW];
   qrs_pkg::kind_type kind_ff [NW];
   logic [1:0]        neg_ff  [NW];
   logic [NW-1:0]     nq_ff   [NW][2];
   logic [RMW-1:0]    rem_ff  [NW-1][2];
   logic [DMW-1:0]    d_ff    [NW-1];

   logic [NW-1:0]     num_mag [2];
   logic [DMW-1:0]    den_mag;
   logic [1:0]        neg0;

   assign num_mag[0] = num_first[NW-1]  ? NW'(-num_first)  : NW'(num_first);
   assign num_mag[1] = num_second[NW-1] ? NW'(-num_second) : NW'(num_second);
   assign den_mag    = den[CW] ? DMW'(-den) : DMW'(den);
   assign neg0       = {num_second[NW-1] ^ den[CW], num_first[NW-1] ^ den[CW]};

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic              v_prev;
      qrs_pkg::kind_type kind_prev;
      logic [1:0]        neg_prev;
      logic [DMW-1:0]    d_prev;

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign kind_prev = in_kind;
         assign neg_prev  = neg0;
         assign d_prev    = den_mag;
      end else begin : g_next
         assign v_prev    = v_ff[s-1];
         assign kind_prev = kind_ff[s-1];
         assign neg_prev  = neg_ff[s-1];
         assign d_prev    = d_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (en) v_ff[s] <= v_prev;
         if (en) begin
            kind_ff[s] <= kind_prev;
            neg_ff[s]  <= neg_prev;
         end
      end

      if (s < NW-1) begin : g_dcarry
         always_ff @(posedge clock) begin
            if (en) d_ff[s] <= d_prev;
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [NW-1:0]  nq_prev;
         logic [RMW-1:0] rem_prev, shifted;
         logic           ge;

         if (s == 0) begin : g_first
            assign nq_prev  = num_mag[l];
            assign rem_prev = '0;
         end else begin : g_next
            assign nq_prev  = nq_ff[s-1][l];
            assign rem_prev = rem_ff[s-1][l];
         end

         assign shifted = {rem_prev[RMW-2:0], nq_prev[NW-1]};
         assign ge      = (shifted >= {1'b0, d_prev});

         always_ff @(posedge clock) begin
            if (en) nq_ff[s][l] <= {nq_prev[NW-2:0], ge};
         end

         if (s < NW-1) begin : g_rcarry
            always_ff @(posedge clock) begin
               if (en) rem_ff[s][l] <= ge ? (shifted - {1'b0, d_prev}) : shifted;
            end
         end
      end
   end

   assign out_valid  = v_ff[NW-1];
   assign out_kind   = kind_ff[NW-1];
   assign quo_first  = nq_ff[NW-1][0];
   assign quo_second = nq_ff[NW-1][1];
   assign quo_neg    = neg_ff[NW-1];

endmodule

// File: hdl/quadratic_root_solver_top.sv
// top level of the quadratic root solver: front end, queue, square root, divider
// depends on qrs_pkg, qrs_front, qrs_queue, qrs_sqrt, qrs_div
//
// Solves a*x^2 + b*x + c = 0 for one coefficient word per cycle when not stalled
// and returns one result word per input word, in order. The front end registers
// the coefficients, forms b*b and a*c, then the exact discriminant and the solution
// kind. A four-entry queue lets the front end keep accepting while the back end
// is stalled. The back end is fully pipelined at one word per cycle when not
// stalled: a square root of COEF_WIDTH+1+FRAC_BITS stages (one root bit each),
// a two-lane divider of COEF_WIDTH+FRAC_BITS+3 stages (one quotient bit each)
// and an output register. Roots are truncated toward zero and saturated to 48
// bits; for the none and infinite kinds both root fields read zero, and for the
// linear and double kinds both fields hold the same root.
module quadratic_root_solver_top #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qrs_pkg::req_type  req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qrs_pkg::rsp_type  rsp
);
   localparam int CW  = qrs_pkg::COEF_WIDTH;
   localparam int RTW = qrs_pkg::ROOT_WIDTH;
   localparam int SW  = CW + 1 + FRAC_BITS;
   localparam int NW  = CW + FRAC_BITS + 3;
   localparam int QW  = NW + 1;
   localparam int EW  = ((QW > RTW) ? QW : RTW) + 1;
   localparam logic signed [EW-1:0] ROOT_MAX = EW'((64'sd1 <<< (RTW-1)) - 64'sd1);
   localparam logic signed [EW-1:0] ROOT_MIN = -ROOT_MAX - EW'(1);

   logic               front_valid, queue_can_push;
   qrs_pkg::entry_type front_entry, head_entry;
   logic               queue_empty, queue_full, pop;
   logic               back_adv;

   logic               sq_valid;
   qrs_pkg::side_type  sq_side;
   logic [SW-1:0]      sq_root;

   logic signed [NW-1:0] nb_ext, root_ext, num_first, num_second;

   logic                 dv_valid;
   qrs_pkg::kind_type    dv_kind;
   logic [NW-1:0]        quo_first, quo_second;
   logic [1:0]           quo_neg;

   logic                 rsp_valid_ff;
   qrs_pkg::rsp_type     rsp_ff, rsp_in;

   function automatic logic signed [RTW-1:0] sat_root(input logic [NW-1:0] mag,
                                                       input logic neg);
      logic signed [QW-1:0] sv;
      logic signed [EW-1:0] ev;
      sv = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      ev = EW'(sv);
      if (ev > ROOT_MAX)      ev = ROOT_MAX;
      else if (ev < ROOT_MIN) ev = ROOT_MIN;
      return ev[RTW-1:0];
   endfunction

   assign back_adv       = !rsp_valid_ff || rsp_ready;
   assign pop            = back_adv && !queue_empty;
   assign queue_can_push = !queue_full || pop;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .out_valid (front_valid),
      .out_ready (queue_can_push),
      .out_entry (front_entry)
   );

   qrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid && queue_can_push),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   qrs_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (back_adv),
      .in_valid  (pop),
      .in_entry  (head_entry),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   // numerators are -b*2^F +/- s (or -c*2^F for the linear case)
   assign nb_ext     = NW'(sq_side.nbase) <<< FRAC_BITS;
   assign root_ext   = NW'($signed({1'b0, sq_root}));
   assign num_first  = nb_ext + root_ext;
   assign num_second = nb_ext - root_ext;

   qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (back_adv),
      .in_valid   (sq_valid),
      .in_kind    (sq_side.kind),
      .num_first  (num_first),
      .num_second (num_second),
      .den        (sq_side.den),
      .out_valid  (dv_valid),
      .out_kind   (dv_kind),
      .quo_first  (quo_first),
      .quo_second (quo_second),
      .quo_neg    (quo_neg)
   );

   always_comb begin
      rsp_in.root_kind   = dv_kind;
      rsp_in.root_first  = sat_root(quo_first, quo_neg[0]);
      rsp_in.root_second = sat_root(quo_second, quo_neg[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (back_adv) rsp_valid_ff <= dv_valid;
      if (back_adv) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
